FILE: rtl/msqd_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// msqd_pkg
// Shared widths, reset value and saturating add for the queue dispatch unit.
// ----------------------------------------------------------------------------
package msqd_pkg;

  localparam int CFG_W       = 4;
  localparam int SVC_W       = 16;
  localparam int PORT_TIME_W = 32;
  localparam int PORT_IDX_W  = 3;
  localparam int SUM_W       = 48;

  localparam logic [CFG_W-1:0] ACTIVE_RESET = 4'd1;

  function automatic logic [SUM_W-1:0] sat_add(input logic [SUM_W-1:0] a,
                                               input logic [SUM_W-1:0] b);
    logic [SUM_W:0] s;
    s = {1'b0, a} + {1'b0, b};
    return s[SUM_W] ? {SUM_W{1'b1}} : s[SUM_W-1:0];
  endfunction

endpackage
`default_nettype wire

FILE: rtl/msqd_pick.sv
`default_nettype none
// ----------------------------------------------------------------------------
// msqd_pick
// Server selection: free finished servers, take the lowest idle one or the
// earliest departure, and form wait, departure and next busy vector.
// ----------------------------------------------------------------------------
module msqd_pick #(
  parameter int NUM_SERVERS = 8,
  parameter int TIME_BITS   = 32,
  localparam int IdxW       = (NUM_SERVERS > 1) ? $clog2(NUM_SERVERS) : 1
) (
  input  wire logic [msqd_pkg::CFG_W-1:0] cfg_active_i,
  input  wire logic [NUM_SERVERS-1:0]     busy_i,
  input  wire logic [TIME_BITS-1:0]       dep_i [NUM_SERVERS],
  input  wire logic [TIME_BITS-1:0]       arrival_i,
  input  wire logic [msqd_pkg::SVC_W-1:0] service_i,
  output logic      [IdxW-1:0]            chosen_o,
  output logic      [TIME_BITS-1:0]       wait_o,
  output logic      [TIME_BITS-1:0]       depart_o,
  output logic      [NUM_SERVERS-1:0]     busy_o
);

  localparam int LeafN = 1 << IdxW;

  logic [7:0]             live;
  logic [NUM_SERVERS-1:0] active;
  logic [NUM_SERVERS-1:0] busy_free;
  logic [NUM_SERVERS-1:0] idle;
  logic [NUM_SERVERS-1:0] lowest;
  logic [IdxW-1:0]        idle_idx;
  logic                   found;
  logic [TIME_BITS-1:0]   start;
  logic [TIME_BITS:0]     dep_sum;

  logic [TIME_BITS-1:0] leaf_dep [LeafN];
  logic                 leaf_vld [LeafN];
  logic [TIME_BITS-1:0] node_dep [1:2*LeafN-1];
  logic [IdxW-1:0]      node_idx [1:2*LeafN-1];
  logic                 node_vld [1:2*LeafN-1];

  always_comb begin
    live = {{(8 - msqd_pkg::CFG_W){1'b0}}, cfg_active_i};
    if (live == 8'd0) begin
      live = 8'd1;
    end
    if (live > 8'(NUM_SERVERS)) begin
      live = 8'(NUM_SERVERS);
    end
    for (int i = 0; i < NUM_SERVERS; i++) begin
      active[i]    = 8'(i) < live;
      busy_free[i] = busy_i[i] && !(active[i] && (dep_i[i] <= arrival_i));
    end
    idle   = active & ~busy_free;
    lowest = idle & (~idle + 1'b1);
    found  = |idle;
    idle_idx = '0;
    for (int i = 0; i < NUM_SERVERS; i++) begin
      if (lowest[i]) begin
        idle_idx = idle_idx | IdxW'(i);
      end
    end
  end

  for (genvar gi = 0; gi < LeafN; gi++) begin : g_leaf
    if (gi < NUM_SERVERS) begin : g_used
      assign leaf_dep[gi] = dep_i[gi];
      assign leaf_vld[gi] = active[gi];
    end else begin : g_pad
      assign leaf_dep[gi] = '0;
      assign leaf_vld[gi] = 1'b0;
    end
  end

  // earliest departure, lower index wins a tie
  always_comb begin
    for (int i = 0; i < LeafN; i++) begin
      node_dep[LeafN+i] = leaf_dep[i];
      node_idx[LeafN+i] = IdxW'(i);
      node_vld[LeafN+i] = leaf_vld[i];
    end
    for (int k = LeafN - 1; k >= 1; k--) begin
      if (node_vld[2*k] && (!node_vld[2*k+1] || (node_dep[2*k] <= node_dep[2*k+1]))) begin
        node_dep[k] = node_dep[2*k];
        node_idx[k] = node_idx[2*k];
        node_vld[k] = node_vld[2*k];
      end else begin
        node_dep[k] = node_dep[2*k+1];
        node_idx[k] = node_idx[2*k+1];
        node_vld[k] = node_vld[2*k+1];
      end
    end
  end

  always_comb begin
    start    = found ? arrival_i : node_dep[1];
    chosen_o = found ? idle_idx : node_idx[1];
    wait_o   = (!found && (start >= arrival_i)) ? (start - arrival_i) : '0;
    dep_sum  = {1'b0, start} + (TIME_BITS+1)'(service_i);
    depart_o = dep_sum[TIME_BITS] ? {TIME_BITS{1'b1}} : dep_sum[TIME_BITS-1:0];
    busy_o   = busy_free;
    for (int i = 0; i < NUM_SERVERS; i++) begin
      if (IdxW'(i) == chosen_o) begin
        busy_o[i] = 1'b1;
      end
    end
  end

endmodule
`default_nettype wire

FILE: rtl/multi_server_queue_dispatch_unit.sv
`default_nettype none
// ----------------------------------------------------------------------------
// multi_server_queue_dispatch_unit
// First-come-first-served dispatch of customers onto a bank of servers.
// ----------------------------------------------------------------------------
// One customer beat is taken per clock cycle while the result channel does
// not stall. The beat is registered at the input register, then the server
// selection (freeing of finished servers, lowest idle server or earliest
// departure tree) updates the server state and loads the result register.
// The combinational selection loop over the registered departure times sets
// the rate of one customer per cycle. A full result register that is stalled
// holds the input register, which in turn raises in_stall_o.
// Write cfg_we_i only while no customer is in flight.
module multi_server_queue_dispatch_unit #(
  parameter int NUM_SERVERS = 8,
  parameter int TIME_BITS   = 32
) (
  input  wire logic                             clk_i,
  input  wire logic                             rst_ni,
  input  wire logic                             cfg_we_i,
  input  wire logic [msqd_pkg::CFG_W-1:0]       cfg_wdata_i,
  input  wire logic                             in_valid_i,
  output logic                                  in_stall_o,
  input  wire logic [msqd_pkg::PORT_TIME_W-1:0] in_arrival_time_i,
  input  wire logic [msqd_pkg::SVC_W-1:0]       in_service_time_i,
  output logic                                  out_valid_o,
  input  wire logic                             out_stall_i,
  output logic      [msqd_pkg::PORT_IDX_W-1:0]  out_server_index_o,
  output logic      [msqd_pkg::PORT_TIME_W-1:0] out_wait_time_o,
  output logic      [msqd_pkg::PORT_TIME_W-1:0] out_departure_time_o,
  output logic      [msqd_pkg::SUM_W-1:0]       out_total_wait_o,
  output logic      [msqd_pkg::SUM_W-1:0]       out_total_system_o,
  output logic      [msqd_pkg::SUM_W-1:0]       out_total_service_o
);

  localparam int IdxW = (NUM_SERVERS > 1) ? $clog2(NUM_SERVERS) : 1;

  logic [msqd_pkg::CFG_W-1:0] cfg_q;

  logic                         s1_valid_q, s1_valid_d;
  logic [TIME_BITS-1:0]         s1_arrival_q;
  logic [msqd_pkg::SVC_W-1:0]   s1_service_q;
  logic                         s1_adv;
  logic                         in_fire;
  logic                         fire;
  logic [63:0]                  arr_ext;

  logic [NUM_SERVERS-1:0] busy_q;
  logic [TIME_BITS-1:0]   dep_q [NUM_SERVERS];

  logic [IdxW-1:0]        pick_chosen;
  logic [TIME_BITS-1:0]   pick_wait;
  logic [TIME_BITS-1:0]   pick_depart;
  logic [NUM_SERVERS-1:0] pick_busy;

  logic                            out_valid_q, out_valid_d;
  logic [msqd_pkg::PORT_IDX_W-1:0] out_server_q;
  logic [msqd_pkg::PORT_TIME_W-1:0] out_wait_q;
  logic [msqd_pkg::PORT_TIME_W-1:0] out_depart_q;
  logic [msqd_pkg::SUM_W-1:0]      wait_sum_q, system_sum_q, service_sum_q;
  logic [msqd_pkg::SUM_W-1:0]      wait_sum_d, system_sum_d, service_sum_d;

  logic [63:0]                wait_ext;
  logic [63:0]                depart_ext;
  logic [63:0]                chosen_ext;
  logic [msqd_pkg::SUM_W-1:0] wait_w;
  logic [msqd_pkg::SUM_W-1:0] svc_w;

  assign s1_adv     = !out_valid_q || !out_stall_i;
  assign in_stall_o = s1_valid_q && !s1_adv;
  assign in_fire    = in_valid_i && !in_stall_o;
  assign fire       = s1_valid_q && s1_adv;
  assign arr_ext    = 64'(in_arrival_time_i);

  always_comb begin
    s1_valid_d = s1_valid_q;
    if (in_fire) begin
      s1_valid_d = 1'b1;
    end else if (s1_adv) begin
      s1_valid_d = 1'b0;
    end
    out_valid_d = out_valid_q;
    if (fire) begin
      out_valid_d = 1'b1;
    end else if (!out_stall_i) begin
      out_valid_d = 1'b0;
    end
  end

  msqd_pick #(
    .NUM_SERVERS (NUM_SERVERS),
    .TIME_BITS   (TIME_BITS)
  ) u_pick (
    .cfg_active_i (cfg_q),
    .busy_i       (busy_q),
    .dep_i        (dep_q),
    .arrival_i    (s1_arrival_q),
    .service_i    (s1_service_q),
    .chosen_o     (pick_chosen),
    .wait_o       (pick_wait),
    .depart_o     (pick_depart),
    .busy_o       (pick_busy)
  );

  always_comb begin
    wait_ext      = 64'(pick_wait);
    depart_ext    = 64'(pick_depart);
    chosen_ext    = 64'(pick_chosen);
    wait_w        = wait_ext[msqd_pkg::SUM_W-1:0];
    svc_w         = msqd_pkg::SUM_W'(s1_service_q);
    wait_sum_d    = msqd_pkg::sat_add(wait_sum_q, wait_w);
    system_sum_d  = msqd_pkg::sat_add(system_sum_q, msqd_pkg::sat_add(wait_w, svc_w));
    service_sum_d = msqd_pkg::sat_add(service_sum_q, svc_w);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q         <= msqd_pkg::ACTIVE_RESET;
      s1_valid_q    <= 1'b0;
      out_valid_q   <= 1'b0;
      busy_q        <= '0;
      wait_sum_q    <= '0;
      system_sum_q  <= '0;
      service_sum_q <= '0;
    end else begin
      if (cfg_we_i) begin
        cfg_q <= cfg_wdata_i;
      end
      s1_valid_q  <= s1_valid_d;
      out_valid_q <= out_valid_d;
      if (fire) begin
        busy_q        <= pick_busy;
        wait_sum_q    <= wait_sum_d;
        system_sum_q  <= system_sum_d;
        service_sum_q <= service_sum_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      s1_arrival_q <= arr_ext[TIME_BITS-1:0];
      s1_service_q <= in_service_time_i;
    end
    if (fire) begin
      dep_q[pick_chosen] <= pick_depart;
      out_server_q       <= chosen_ext[msqd_pkg::PORT_IDX_W-1:0];
      out_wait_q         <= wait_ext[msqd_pkg::PORT_TIME_W-1:0];
      out_depart_q       <= depart_ext[msqd_pkg::PORT_TIME_W-1:0];
    end
  end

  assign out_valid_o          = out_valid_q;
  assign out_server_index_o   = out_server_q;
  assign out_wait_time_o      = out_wait_q;
  assign out_departure_time_o = out_depart_q;
  assign out_total_wait_o     = wait_sum_q;
  assign out_total_system_o   = system_sum_q;
  assign out_total_service_o  = service_sum_q;

`ifndef SYNTHESIS
  a_chosen_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $past(fire) |-> busy_q[$past(pick_chosen)])
    else $error("assigned server not marked busy");

  a_wait_monotonic: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fire |=> (wait_sum_q >= $past(wait_sum_q)))
    else $error("wait total decreased");

  a_system_ge_service: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (system_sum_q >= service_sum_q) && (system_sum_q >= wait_sum_q))
    else $error("system total below a component total");

  a_stall_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> (out_valid_q && out_stall_i && s1_valid_q))
    else $error("input stalled without a held result");
`endif

endmodule
`default_nettype wire

FILE: test/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the multi-server queue dispatch unit.
// ----------------------------------------------------------------------------
// Customer beats go in with random gaps while the result channel stalls at
// random. Each result beat is compared field by field with a behavioral
// dispatch model kept in the bench. Directed tests cover the reset setting,
// active-count extremes, servers outside the active range, saturated
// departures and backward arrivals. They are followed by random traffic over
// several settings and a long receiver hold-off.
// ----------------------------------------------------------------------------
module tb_top;

  localparam int CFG_W       = msqd_pkg::CFG_W;
  localparam int SVC_W       = msqd_pkg::SVC_W;
  localparam int PORT_TIME_W = msqd_pkg::PORT_TIME_W;
  localparam int PORT_IDX_W  = msqd_pkg::PORT_IDX_W;
  localparam int SUM_W       = msqd_pkg::SUM_W;
  localparam logic [CFG_W-1:0] ACTIVE_RESET = msqd_pkg::ACTIVE_RESET;

  localparam int SERVERS      = 8;
  localparam int DRAIN_CYCLES = 8;
  localparam int STALL_LIMIT  = 2000;
  localparam int HOLD_CYCLES  = 300;
  localparam int IDLE_PCT     = 37;
  localparam int MAX_REPORTS  = 40;
  localparam logic [SUM_W-1:0] SUM_CEIL = {SUM_W{1'b1}};

  typedef logic [PORT_TIME_W-1:0] tick_t;
  typedef logic [SVC_W-1:0]       svc_t;
  typedef logic [SUM_W-1:0]       sum_t;

  typedef struct packed {
    logic [PORT_IDX_W-1:0] server;
    tick_t                 waited;
    tick_t                 depart;
    sum_t                  wait_total;
    sum_t                  system_total;
    sum_t                  service_total;
  } dispatch_t;

  logic                   clk_i = 1'b0;
  logic                   rst_ni;
  logic                   cfg_we_i;
  logic [CFG_W-1:0]       cfg_wdata_i;
  logic                   in_valid_i;
  logic                   in_stall_o;
  logic [PORT_TIME_W-1:0] in_arrival_time_i;
  logic [SVC_W-1:0]       in_service_time_i;
  logic                   out_valid_o;
  logic                   out_stall_i;
  logic [PORT_IDX_W-1:0]  out_server_index_o;
  logic [PORT_TIME_W-1:0] out_wait_time_o;
  logic [PORT_TIME_W-1:0] out_departure_time_o;
  logic [SUM_W-1:0]       out_total_wait_o;
  logic [SUM_W-1:0]       out_total_system_o;
  logic [SUM_W-1:0]       out_total_service_o;

  multi_server_queue_dispatch_unit #(
    .NUM_SERVERS(SERVERS),
    .TIME_BITS  (PORT_TIME_W)
  ) dut (
    .clk_i               (clk_i),
    .rst_ni              (rst_ni),
    .cfg_we_i            (cfg_we_i),
    .cfg_wdata_i         (cfg_wdata_i),
    .in_valid_i          (in_valid_i),
    .in_stall_o          (in_stall_o),
    .in_arrival_time_i   (in_arrival_time_i),
    .in_service_time_i   (in_service_time_i),
    .out_valid_o         (out_valid_o),
    .out_stall_i         (out_stall_i),
    .out_server_index_o  (out_server_index_o),
    .out_wait_time_o     (out_wait_time_o),
    .out_departure_time_o(out_departure_time_o),
    .out_total_wait_o    (out_total_wait_o),
    .out_total_system_o  (out_total_system_o),
    .out_total_service_o (out_total_service_o)
  );

  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  // Dispatch model state
  logic [CFG_W-1:0]       active_cfg = ACTIVE_RESET;
  bit                     srv_busy   [SERVERS];
  bit [PORT_TIME_W-1:0]   srv_depart [SERVERS];
  bit [SUM_W-1:0]         sum_wait;
  bit [SUM_W-1:0]         sum_system;
  bit [SUM_W-1:0]         sum_service;

  dispatch_t pending_results[$];
  int        fail_count      = 0;
  int        customers_sent  = 0;
  int        results_checked = 0;
  int        cfg_writes      = 0;
  int        quiet_cycles    = 0;
  int        hold_left       = 0;
  bit        hold_request    = 1'b0;
  bit        sender_idles    = 1'b1;
  bit        receiver_idles  = 1'b1;

  function automatic sum_t clamp_sum(input sum_t a, input sum_t b);
    logic [SUM_W:0] total;
    total = {1'b0, a} + {1'b0, b};
    return (total > {1'b0, SUM_CEIL}) ? SUM_CEIL : total[SUM_W-1:0];
  endfunction

  function automatic dispatch_t dispatch_customer(input tick_t arrival, input svc_t service);
    dispatch_t        r;
    int               n;
    int               pick;
    bit               found;
    tick_t            start;
    tick_t            waited;
    logic [PORT_TIME_W:0] end_tick;
    n = int'(active_cfg);
    if (n == 0) n = 1;
    if (n > SERVERS) n = SERVERS;
    for (int i = 0; i < n; i++) begin
      if (srv_busy[i] && srv_depart[i] <= arrival) srv_busy[i] = 1'b0;
    end
    found = 1'b0;
    pick  = 0;
    for (int i = 0; i < n; i++) begin
      if (!found && !srv_busy[i]) begin
        pick  = i;
        found = 1'b1;
      end
    end
    start  = arrival;
    waited = '0;
    if (!found) begin
      pick = 0;
      for (int i = 1; i < n; i++) begin
        if (srv_depart[i] < srv_depart[pick]) pick = i;
      end
      start  = srv_depart[pick];
      waited = (start >= arrival) ? start - arrival : '0;
    end
    end_tick = {1'b0, start} + {{(PORT_TIME_W + 1 - SVC_W){1'b0}}, service};
    if (end_tick[PORT_TIME_W]) end_tick = {1'b0, {PORT_TIME_W{1'b1}}};
    srv_busy[pick]   = 1'b1;
    srv_depart[pick] = end_tick[PORT_TIME_W-1:0];
    sum_wait    = clamp_sum(sum_wait, sum_t'(waited));
    sum_system  = clamp_sum(sum_system, clamp_sum(sum_t'(waited), sum_t'(service)));
    sum_service = clamp_sum(sum_service, sum_t'(service));
    r.server        = pick[PORT_IDX_W-1:0];
    r.waited        = waited;
    r.depart        = end_tick[PORT_TIME_W-1:0];
    r.wait_total    = sum_wait;
    r.system_total  = sum_system;
    r.service_total = sum_service;
    return r;
  endfunction

  task automatic check_field(input string tag, input sum_t want, input sum_t got);
    if (want !== got) begin
      fail_count++;
      if (fail_count <= MAX_REPORTS)
        $display("%0t: %s mismatch, expected %0h, actual %0h", $time, tag, want, got);
    end
  endtask

  task automatic check_result();
    dispatch_t want;
    if (pending_results.size() == 0) begin
      fail_count++;
      if (fail_count <= MAX_REPORTS)
        $display("%0t: result beat with no customer pending, expected none, actual server %0d",
                 $time, out_server_index_o);
    end else begin
      want = pending_results.pop_front();
      check_field("server_index", sum_t'(want.server), sum_t'(out_server_index_o));
      check_field("wait_time", sum_t'(want.waited), sum_t'(out_wait_time_o));
      check_field("departure_time", sum_t'(want.depart), sum_t'(out_departure_time_o));
      check_field("total_wait", want.wait_total, out_total_wait_o);
      check_field("total_system", want.system_total, out_total_system_o);
      check_field("total_service", want.service_total, out_total_service_o);
      results_checked++;
    end
  endtask

  // Result side: check, then pick the stall for the next cycle
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i) check_result();
    if (hold_request) begin
      hold_left    = HOLD_CYCLES;
      hold_request = 1'b0;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_stall_i <= 1'b1;
    end else if (receiver_idles) begin
      out_stall_i <= ($urandom_range(99) < IDLE_PCT);
    end else begin
      out_stall_i <= 1'b0;
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) quiet_cycles = 0;
      else quiet_cycles++;
      if (quiet_cycles >= STALL_LIMIT) begin
        $display("%0t: no beat for %0d cycles, %0d results outstanding",
                 $time, quiet_cycles, pending_results.size());
        $display("Verification failed");
        $finish;
      end
    end
  end

  task automatic send_customer(input tick_t arrival, input svc_t service);
    if (sender_idles) begin
      while ($urandom_range(99) < IDLE_PCT) begin
        in_valid_i <= 1'b0;
        @(posedge clk_i);
      end
    end
    in_valid_i        <= 1'b1;
    in_arrival_time_i <= arrival;
    in_service_time_i <= service;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    pending_results.push_back(dispatch_customer(arrival, service));
    customers_sent++;
  endtask

  task automatic drain_results();
    in_valid_i <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  task automatic write_active_servers(input logic [CFG_W-1:0] value);
    drain_results();
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= value;
    @(posedge clk_i);
    cfg_we_i   <= 1'b0;
    active_cfg = value;
    cfg_writes++;
  endtask

  task automatic test_reset_defaults();
    send_customer(32'd0, 16'd0);
    send_customer(32'd0, 16'd5);
    send_customer(32'd1, 16'd3);
    send_customer(32'd20, 16'hFFFF);
  endtask

  task automatic test_active_count_extremes();
    // zero acts as one server
    write_active_servers(4'd0);
    send_customer(32'd30, 16'd2);
    send_customer(32'd30, 16'd2);
    // above the bank size clamps; ninth customer ties on departure
    write_active_servers(4'hF);
    for (int k = 0; k < 9; k++) send_customer(32'h0002_0000, 16'd7);
  endtask

  task automatic test_inactive_servers();
    write_active_servers(4'd2);
    send_customer(32'h0003_0000, 16'd1);
    // backward arrival: servers left out above must still be busy
    write_active_servers(4'd8);
    send_customer(32'h0002_0000, 16'd1);
  endtask

  task automatic test_departure_overflow();
    send_customer(32'hFFFF_FFFF, 16'hFFFF);
    send_customer(32'hFFFF_FFF0, 16'h0020);
    send_customer(32'h0000_0000, 16'h0000);
    send_customer(32'h8000_0000, 16'h8000);
  endtask

  task automatic test_random_traffic();
    tick_t arrival;
    svc_t  service;
    int    gap_max;
    int    pick;
    for (int phase = 0; phase < 8; phase++) begin
      if (phase == 0) write_active_servers(4'd1);
      else if (phase == 1) write_active_servers(4'd8);
      else if ($urandom_range(3) == 0) write_active_servers(CFG_W'($urandom_range(0, 15)));
      else write_active_servers(CFG_W'($urandom_range(1, 8)));
      // long stretch with no idling on either side
      sender_idles   = (phase != 3);
      receiver_idles = (phase != 3);
      arrival = $urandom();
      gap_max = ($urandom_range(3) == 0) ? 200 : $urandom_range(1, 24);
      for (int k = 0; k < 42; k++) begin
        pick = $urandom_range(99);
        if (pick < 4) arrival = $urandom();
        else if (pick < 8) arrival = arrival - tick_t'($urandom_range(0, 50));
        else arrival = arrival + tick_t'($urandom_range(0, gap_max));
        pick = $urandom_range(99);
        if (pick < 75) service = svc_t'($urandom_range(0, 64));
        else if (pick < 90) service = svc_t'($urandom());
        else if (pick < 95) service = '1;
        else service = '0;
        send_customer(arrival, service);
      end
    end
    sender_idles   = 1'b1;
    receiver_idles = 1'b1;
  endtask

  task automatic test_backpressure();
    tick_t arrival;
    write_active_servers(4'd4);
    sender_idles = 1'b0;
    hold_request = 1'b1;
    @(posedge clk_i);
    arrival = 32'h0100_0000;
    for (int k = 0; k < 40; k++) begin
      arrival = arrival + tick_t'($urandom_range(0, 3));
      send_customer(arrival, svc_t'($urandom_range(1, 30)));
    end
    // hold the sender until every result is back
    drain_results();
    sender_idles = 1'b1;
  endtask

  initial begin
    rst_ni            <= 1'b0;
    cfg_we_i          <= 1'b0;
    cfg_wdata_i       <= '0;
    in_valid_i        <= 1'b0;
    in_arrival_time_i <= '0;
    in_service_time_i <= '0;
    out_stall_i       <= 1'b0;
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_reset_defaults();
    test_active_count_extremes();
    test_inactive_servers();
    test_departure_overflow();
    test_random_traffic();
    test_backpressure();
    drain_results();

    $display("Checked %0d of %0d customers over %0d active-server writes,", results_checked,
             customers_sent, cfg_writes);
    $display("with random gaps, backward and wrapping arrivals and a long output hold-off.");
    if (fail_count == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
